// ===== hw/rtl/fde_pkg.sv =====
// ============================================================================
// fde_pkg
// Shared types and constants of the finite-difference extrapolator.
// ============================================================================
`default_nettype none

package fde_pkg;

  localparam int MAX_LEN_DEF = 32;   // default depth of the difference table
  localparam int SAMPLE_BITS = 24;   // width of one input sample
  localparam int VALUE_BITS  = 64;   // width of differences, sums and totals

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] next_value;
    logic signed [VALUE_BITS-1:0] previous_value;
    logic signed [VALUE_BITS-1:0] total_next;
    logic signed [VALUE_BITS-1:0] total_previous;
    logic                         too_long;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // load sign-extended sample into the carry, clear next sum
    logic step;      // write carry into the table, add it to the next sum
    logic close;     // highest order reached: fold carry into previous sum
    logic neg;       // odd order: subtract instead of add
    logic finish;    // form the result, advance totals, clear previous sum
    logic too_long;  // overflow flag of the sequence being closed
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/finite_difference_extrapolator.sv =====
// ============================================================================
// finite_difference_extrapolator
// Newton forward-difference extrapolation over a sample stream: emits the
// next and the preceding value of each sequence plus running totals.
// ============================================================================
//
//   channel  direction  payload         transaction
//   in_      input      fde_pkg::in_t   one sample, last marks end of sequence
//   out_     output     fde_pkg::out_t  one result per sequence
//
// A sample taken at position p (0-based within its sequence) is first
// accepted, then takes p+1 passes of the shared subtract/accumulate step
// over the difference table memory, one order per cycle. A sample beyond
// MAX_LEN is accepted and dropped. After the last sample of a sequence, a
// finish step forms the result once the output register is free. Reset is
// synchronous, active low, and needs no clearing pass. A stalled result
// holds in the output register; the next sequence runs meanwhile and only
// waits if its own result is ready before the old one is taken.
// ============================================================================
`default_nettype none

module finite_difference_extrapolator #(
  parameter int MAX_LEN = fde_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire fde_pkg::in_t  in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      fde_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(MAX_LEN);

  fde_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  // Sequencer: order walk, length tracking, result valid
  fde_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // Table, carry chain, sums and result register. The sample is needed on
  // the bus only in the accept cycle, which is when the datapath latches it.
  fde_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample   (in_data.sample),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .out_data (out_data)
  );

  // A sample without the last mark never releases a result next cycle
  a_no_result_mid_sequence: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.last) |=> !$rose(out_valid)
  ) else $error("result raised after a sample that did not end a sequence");

  // An accepted last sample always keeps the block busy next cycle
  a_busy_after_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall
  ) else $error("input not held off while closing a sequence");

  // Reset drops any pending result
  a_reset_clears_result: assert property (
    @(posedge clk)
    !rst_n |=> !out_valid
  ) else $error("result valid survived reset");

endmodule

`default_nettype wire

// ===== hw/rtl/fde_ctrl.sv =====
// ============================================================================
// fde_ctrl
// Sequencer: walks the orders of the difference table per sample, tracks the
// sequence length and overflow, and owns the result valid flag.
// ============================================================================
`default_nettype none

module fde_ctrl #(
  parameter int MAX_LEN = fde_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_last,
  output      logic                         in_stall,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      fde_pkg::cmd_t                cmd,
  output      logic [$clog2(MAX_LEN)-1:0]   wr_addr,
  output      logic [$clog2(MAX_LEN)-1:0]   rd_addr
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int POS_W = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic             room;
  logic             at_end;
  logic             out_free;
  logic [IDX_W-1:0] k_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign room      = (pos_r < POS_W'(MAX_LEN));
  assign at_end    = (POS_W'(k_r) == pos_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign k_inc     = (k_r == IDX_W'(MAX_LEN - 1)) ? '0 : k_r + 1'b1;
  assign out_valid = out_valid_r;
  assign wr_addr   = k_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    rd_addr   = '0;
    cmd       = '0;
    cmd.too_long = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          if (room) begin
            cmd.start = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_RUN;
          end else begin
            ovf_nxt = 1'b1;
            if (in_last) begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        rd_addr  = k_inc;
        if (at_end) begin
          cmd.close = 1'b1;
          cmd.neg   = k_r[0];
          pos_nxt   = pos_r + 1'b1;
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end else begin
          k_nxt = k_inc;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          pos_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fde_datapath.sv =====
// ============================================================================
// fde_datapath
// Difference table memory, carry chain, per-sequence sums, running totals
// and the result register.
// ============================================================================
`default_nettype none

module fde_datapath #(
  parameter int MAX_LEN = fde_pkg::MAX_LEN_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic signed [fde_pkg::SAMPLE_BITS-1:0] sample,
  input  wire fde_pkg::cmd_t                          cmd,
  input  wire logic [$clog2(MAX_LEN)-1:0]             wr_addr,
  input  wire logic [$clog2(MAX_LEN)-1:0]             rd_addr,
  output      fde_pkg::out_t                          out_data
);

  localparam int VB = fde_pkg::VALUE_BITS;
  localparam int SB = fde_pkg::SAMPLE_BITS;

  logic [VB-1:0] lat_mem [MAX_LEN];
  logic [VB-1:0] rdata_r;

  logic [VB-1:0] carry_r;
  logic [VB-1:0] next_acc_r;
  logic [VB-1:0] prev_acc_r;
  logic [VB-1:0] tot_next_r;
  logic [VB-1:0] tot_prev_r;
  fde_pkg::out_t out_r;

  logic [VB-1:0] sample_ext;
  logic [VB-1:0] tot_next_sum;
  logic [VB-1:0] tot_prev_sum;

  assign sample_ext   = {{(VB-SB){sample[SB-1]}}, sample};
  assign tot_next_sum = tot_next_r + next_acc_r;
  assign tot_prev_sum = tot_prev_r + prev_acc_r;
  assign out_data     = out_r;

  // Newest value of each order
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      lat_mem[wr_addr] <= carry_r;
    end
    rdata_r <= lat_mem[rd_addr];
  end

  // Carry chain, per-sequence sums and result register; payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      carry_r    <= sample_ext;
      next_acc_r <= '0;
    end else if (cmd.step) begin
      next_acc_r <= next_acc_r + carry_r;
      if (!cmd.close) begin
        carry_r <= carry_r - rdata_r;
      end
    end
    if (cmd.finish) begin
      out_r.next_value     <= next_acc_r;
      out_r.previous_value <= prev_acc_r;
      out_r.total_next     <= tot_next_sum;
      out_r.total_previous <= tot_prev_sum;
      out_r.too_long       <= cmd.too_long;
    end
  end

  // Alternating sum of first values and the running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_acc_r <= '0;
      tot_next_r <= '0;
      tot_prev_r <= '0;
    end else begin
      if (cmd.finish) begin
        prev_acc_r <= '0;
        tot_next_r <= tot_next_sum;
        tot_prev_r <= tot_prev_sum;
      end else if (cmd.close) begin
        prev_acc_r <= cmd.neg ? prev_acc_r - carry_r : prev_acc_r + carry_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_finite_difference_extrapolator.sv =====
// ----------------------------------------------------------------------------
// tb_finite_difference_extrapolator
// Streams integer sequences through the extrapolator and checks every result
// (next value, preceding value, running totals, overflow flag) against a
// difference-table model kept in a small scoreboard class.
// ----------------------------------------------------------------------------

module tb_finite_difference_extrapolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS   = fde_pkg::VALUE_BITS;
  localparam int SAMPLE_BITS  = fde_pkg::SAMPLE_BITS;
  localparam int TABLE_DEPTH  = fde_pkg::MAX_LEN_DEF;
  localparam int ITEM_TARGET  = 1050;
  localparam int IDLE_PCT     = 31;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;        // well above the slowest sample
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int REPORT_MAX   = 10;

  typedef enum int {SEQ_WIDE, SEQ_NARROW, SEQ_POLY, SEQ_FLAT} seq_kind_t;

  // Difference table model plus the queue of results still owed by the block
  class extrapolation_scoreboard;
    logic [VALUE_BITS-1:0] newest [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] earliest [TABLE_DEPTH];
    int unsigned           depth;
    logic [VALUE_BITS-1:0] run_next;
    logic [VALUE_BITS-1:0] run_prev;
    bit                    spilled;
    fde_pkg::out_t         owed [$];
    int                    mismatches;

    function new();
      foreach (newest[k]) newest[k] = '0;
      foreach (earliest[k]) earliest[k] = '0;
      depth = 0;
      run_next = '0;
      run_prev = '0;
      spilled = 1'b0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void flag(string what, logic [VALUE_BITS-1:0] want,
                       logic [VALUE_BITS-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t mismatch on %s: expected %0d (0x%h), got %0d (0x%h)",
                 $time, what, $signed(want), want, $signed(got), got);
    endfunction

    // Push the sample through the table; on the last one, owe a result
    function void note_sample(fde_pkg::in_t t);
      logic [VALUE_BITS-1:0] carry;
      logic [VALUE_BITS-1:0] old;
      logic [VALUE_BITS-1:0] nxt;
      logic [VALUE_BITS-1:0] prv;
      fde_pkg::out_t         res;
      if (depth < TABLE_DEPTH) begin
        carry = {{(VALUE_BITS-SAMPLE_BITS){t.sample[SAMPLE_BITS-1]}}, t.sample};
        for (int k = 0; k <= depth; k++) begin
          old = newest[k];
          newest[k] = carry;
          if (k == depth) earliest[k] = carry;
          carry = carry - old;
        end
        depth++;
      end else begin
        spilled = 1'b1;
      end
      if (!t.last) return;
      nxt = '0;
      prv = '0;
      for (int k = 0; k < depth; k++) begin
        nxt += newest[k];
        if (k % 2 == 1) prv -= earliest[k];
        else prv += earliest[k];
      end
      run_next += nxt;
      run_prev += prv;
      res.next_value     = nxt;
      res.previous_value = prv;
      res.total_next     = run_next;
      res.total_previous = run_prev;
      res.too_long       = spilled;
      owed = {owed, res};
      depth = 0;
      spilled = 1'b0;
    endfunction

    function void check_result(fde_pkg::out_t got);
      fde_pkg::out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t unexpected result: next %0d previous %0d", $time,
                   got.next_value, got.previous_value);
        return;
      end
      want = owed.pop_front();
      if (got.next_value !== want.next_value)
        flag("next_value", want.next_value, got.next_value);
      if (got.previous_value !== want.previous_value)
        flag("previous_value", want.previous_value, got.previous_value);
      if (got.total_next !== want.total_next)
        flag("total_next", want.total_next, got.total_next);
      if (got.total_previous !== want.total_previous)
        flag("total_previous", want.total_previous, got.total_previous);
      if (got.too_long !== want.too_long)
        flag("too_long", 64'(want.too_long), 64'(got.too_long));
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  fde_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  fde_pkg::out_t out_data;

  // Shared between the sender and the receiver
  logic steady    = 1'b0;   // no idling on either side while high
  logic hold_req  = 1'b0;   // ask the receiver for its long hold-off

  extrapolation_scoreboard ledger = new();
  int unsigned samples_sent = 0;
  longint unsigned cycles = 0;

  finite_difference_extrapolator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               ledger.outstanding());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each transaction taken at this edge, then pick the
  // stall for the next cycle. The long hold-off is counted here, so the
  // sender keeps offering samples until the block backs up into in_stall.
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_result(out_data);
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one sample, with optional idle cycles first; return once taken.
  // Valid stays high on return so back-to-back samples need no gap.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, logic is_last);
    fde_pkg::in_t t;
    t.sample = value;
    t.last   = is_last;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ledger.note_sample(t);
    samples_sent++;
  endtask

  // Generate one sequence of the given shape; the final sample carries last
  task automatic send_sequence(int len, seq_kind_t kind);
    int c0;
    int c1;
    int c2;
    int c3;
    int v;
    c0 = $urandom_range(2000) - 1000;
    c1 = $urandom_range(200) - 100;
    c2 = $urandom_range(20) - 10;
    c3 = $urandom_range(4) - 2;
    for (int n = 0; n < len; n++) begin
      case (kind)
        SEQ_WIDE:   v = $urandom();
        SEQ_NARROW: v = $urandom_range(64) - 32;
        SEQ_POLY:   v = c0 + c1 * n + c2 * n * n + c3 * n * n * n;
        default:    v = c0;
      endcase
      send_sample(v[SAMPLE_BITS-1:0], n == len - 1);
    end
  endtask

  // Drop valid and hold until every owed result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int        len;
    int        pick;
    seq_kind_t kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-sample sequences (all higher orders empty)
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(-24'sh800000, 1'b1);
    send_sample(24'sd0, 1'b1);
    // Constant sequence: every row beyond the first is all zero
    send_sample(24'sd5, 1'b0);
    send_sample(24'sd5, 1'b0);
    send_sample(24'sd5, 1'b1);
    // Alternating extremes: differences far outside the sample range
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b1);
    // Squares: fourth row is all zero
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sd4, 1'b0);
    send_sample(24'sd9, 1'b0);
    send_sample(24'sd16, 1'b1);
    // Short descending pair
    send_sample(-24'sd1, 1'b0);
    send_sample(-24'sd7, 1'b1);

    // Full table with the last marker fitting exactly, then overflow where
    // the marked sample itself is dropped, then a longer overflow
    send_sequence(TABLE_DEPTH, SEQ_POLY);
    send_sequence(TABLE_DEPTH + 1, SEQ_WIDE);
    send_sequence(TABLE_DEPTH + 6, SEQ_NARROW);

    // Pause the sender until the block has returned everything
    wait_drained();

    while (samples_sent < ITEM_TARGET) begin
      // Open a stretch with no idling on either side
      if (samples_sent >= 500 && samples_sent < 700) steady <= 1'b1;
      else steady <= 1'b0;
      // Freeze the receiver while samples keep coming
      if (samples_sent >= 300) hold_req <= 1'b1;
      if (samples_sent >= 800 && samples_sent < 820) wait_drained();

      pick = $urandom_range(99);
      if (pick < 55) len = $urandom_range(6, 1);
      else if (pick < 80) len = $urandom_range(16, 7);
      else if (pick < 92) len = $urandom_range(TABLE_DEPTH, 17);
      else len = $urandom_range(TABLE_DEPTH + 8, TABLE_DEPTH + 1);
      kind = seq_kind_t'($urandom_range(3));
      send_sequence(len, kind);
    end

    steady <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
